// ===== rtl/arq_pkg.sv =====
// Shared types, constants and helper functions of the arcball rotation block.
package arq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int QFX_W = 16;
  localparam int VAL_W = 18;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int RAD_W = 32;
  localparam int ROOT_W = RAD_W / 2;
  localparam int DIV_W = 32;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int ONE_SQ = 1 << (2 * FRAC_BITS);
  localparam int HALF = 1 << (FRAC_BITS - 1);

  localparam int CORDIC_STEPS = 20;
  localparam int ATAN_W = 22;
  localparam int DEG16_90 = 90 << 16;
  localparam int DEG16_180 = 180 << 16;

  localparam logic [15:0] ANGLE_RESET = 16'(180 << 7);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [QFX_W-1:0] qfx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_POST,
    ST_SQRT,
    ST_DIV,
    ST_DIVW,
    ST_CORD,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    PH_SPH_S,
    PH_SPH_C,
    PH_MAG_S,
    PH_MAG_C,
    PH_CR,
    PH_MAG_R,
    PH_DOT,
    PH_CH,
    PH_SH,
    PH_QV,
    PH_W,
    PH_V,
    PH_S,
    PH_ANG,
    PH_AX
  } phase_t;

  function automatic logic [2:0] phase_terms(phase_t ph);
    logic [2:0] n;
    unique case (ph)
      PH_SPH_S, PH_SPH_C, PH_CR:       n = 3'd2;
      PH_MAG_S, PH_MAG_C, PH_MAG_R,
      PH_DOT:                          n = 3'd3;
      PH_QV, PH_S:                     n = 3'd1;
      PH_W, PH_V:                      n = 3'd4;
      default:                         n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic phase_t next_phase(phase_t ph);
    phase_t n;
    unique case (ph)
      PH_SPH_C: n = PH_MAG_S;
      PH_MAG_S: n = PH_MAG_C;
      PH_MAG_C: n = PH_CR;
      PH_CR:    n = PH_MAG_R;
      PH_MAG_R: n = PH_DOT;
      PH_DOT:   n = PH_CH;
      PH_CH:    n = PH_SH;
      PH_SH:    n = PH_QV;
      PH_QV:    n = PH_W;
      PH_W:     n = PH_V;
      PH_V:     n = PH_S;
      PH_S:     n = PH_ANG;
      PH_ANG:   n = PH_AX;
      default:  n = PH_AX;
    endcase
    return n;
  endfunction

  function automatic qfx_t clamp_one(logic signed [ACC_W-1:0] v);
    qfx_t r;
    if (v > ACC_W'(ONE)) begin
      r = qfx_t'(ONE);
    end else if (v < -ACC_W'(ONE)) begin
      r = -qfx_t'(ONE);
    end else begin
      r = qfx_t'(v);
    end
    return r;
  endfunction

  function automatic qfx_t sat16(logic signed [DIV_W-1:0] v);
    qfx_t r;
    if (v > DIV_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -DIV_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = qfx_t'(v);
    end
    return r;
  endfunction

  function automatic logic [ATAN_W-1:0] atan_deg(logic [4:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      5'd0:    a = 22'd2949120;
      5'd1:    a = 22'd1740967;
      5'd2:    a = 22'd919879;
      5'd3:    a = 22'd466945;
      5'd4:    a = 22'd234379;
      5'd5:    a = 22'd117304;
      5'd6:    a = 22'd58666;
      5'd7:    a = 22'd29335;
      5'd8:    a = 22'd14668;
      5'd9:    a = 22'd7334;
      5'd10:   a = 22'd3667;
      5'd11:   a = 22'd1833;
      5'd12:   a = 22'd917;
      5'd13:   a = 22'd458;
      5'd14:   a = 22'd229;
      5'd15:   a = 22'd115;
      5'd16:   a = 22'd57;
      5'd17:   a = 22'd29;
      5'd18:   a = 22'd14;
      5'd19:   a = 22'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/arq_isqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
module arq_isqrt import arq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [RAD_W:0]   trial;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};

  always_comb begin
    n_nxt = n_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt = radicand;
      res_nxt = '0;
      bit_nxt = RAD_W'(1) << (RAD_W - 2);
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, n_r} >= trial) begin
        n_nxt = RAD_W'({1'b0, n_r} - trial);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

// ===== rtl/arq_div.sv =====
// Iterative restoring divider, quotient rounded half away from zero.
module arq_div import arq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] num,
  input  logic [ROOT_W-1:0]       den,
  output logic                    done,
  output logic signed [DIV_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  dvd_r, dvd_nxt, mag;
  logic [ROOT_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [ROOT_W:0]   rem_sh;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;

  assign mag = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = mag + DIV_W'(den >> 1);
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = '0;
      neg_nxt = num[DIV_W-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = ROOT_W'(rem_sh - {1'b0, den_r});
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[ROOT_W-1:0];
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(dvd_r) : $signed(dvd_r);

endmodule

// ===== rtl/arq_cordic.sv =====
// Iterative vectoring CORDIC giving the doubled half angle in Q9.7 degrees.
module arq_cordic import arq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  qfx_t        cx,
  input  logic [ROOT_W-1:0] sy,
  output logic        done,
  output logic [15:0] angle
);

  localparam int XY_W = 18;
  localparam int Z_W = 26;
  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [Z_W-1:0]  z_r, z_nxt, zc, at;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic                   busy_r, busy_nxt, done_r, done_nxt;
  logic [Z_W:0]           dbl;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = Z_W'(atan_deg(i_r));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      if (cx < 0) begin
        x_nxt = XY_W'($signed({1'b0, sy}));
        y_nxt = -XY_W'(cx);
        z_nxt = Z_W'(DEG16_90);
      end else begin
        x_nxt = XY_W'(cx);
        y_nxt = XY_W'($signed({1'b0, sy}));
        z_nxt = '0;
      end
      i_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
      i_nxt = i_r + CNT_W'(1);
      if (i_r == CNT_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (z_r < 0) begin
      zc = '0;
    end else if (z_r > Z_W'(DEG16_180)) begin
      zc = Z_W'(DEG16_180);
    end else begin
      zc = z_r;
    end
  end

  assign dbl = {zc, 1'b0} + (Z_W + 1)'(256);
  assign angle = dbl[24:9];

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/arcball_quaternion_rotation.sv =====
// Arcball rotation top level: sequencer, shared multiply-accumulate and result register.
//
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | [15:0] pos_x, [31:16] pos_y             | [0] action, [1] chord, [2] release
//  out_    | master    | [15:0] rot_angle, [31:16] axis_x,       | [0] dragging
//          |           | [47:32] axis_y, [63:48] axis_z          |
//
// A cursor move during a drag runs the divider up to twelve times; a chord press needs at
// most one square root; any other event goes straight to the result register.
// in_tready is high only while the sequencer is idle; one result per transfer in.
// The result register holds a transfer until out_tready; the next input is taken meanwhile.
// rst_n is synchronous and restores the 180 degree rotation about x.
module arcball_quaternion_rotation import arq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pos_x, pos_y
  input  logic [2:0]  in_tuser,   // action, drag_chord_held, is_release
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // rot_angle, axis_x, axis_y, axis_z
  output logic        out_tuser   // dragging
);

  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [1:0] j_r, j_nxt, k_r, k_nxt;

  qfx_t in_x_r, in_x_nxt, in_y_r, in_y_nxt;
  val_t sp_r [3], sp_nxt [3];
  val_t cur_r [3], cur_nxt [3];
  val_t su_r [3], su_nxt [3];
  val_t cu_r [3], cu_nxt [3];
  val_t cr_r [3], cr_nxt [3];
  val_t ax_r [3], ax_nxt [3];
  val_t qv_r [3], qv_nxt [3];
  logic [ROOT_W-1:0] mag_r, mag_nxt, ch_r, ch_nxt, sh_r, sh_nxt, s_r, s_nxt;
  qfx_t c_r, c_nxt;
  qfx_t cq_r [4], cq_nxt [4];
  qfx_t pq_r [4], pq_nxt [4];
  logic [15:0] ang_r, ang_nxt;
  qfx_t axis_r [3], axis_nxt [3];
  logic drag_r, drag_nxt;

  logic signed [PROD_W-1:0] prod_r, prod_nxt, mul_p;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, rs;

  logic        ov_r, ov_nxt, ou_r, ou_nxt;
  logic [63:0] od_r, od_nxt;

  val_t a_op, b_op;
  logic neg_op;
  logic [1:0] idx1, idx2, j1;

  logic in_fire, out_free, mac_last, outside, fin;
  logic post_fin, sqrt_fin, divw_fin, cord_fin;

  logic sq_start, sq_done, dv_start, dv_done, co_start, co_done;
  logic [RAD_W-1:0] sq_rad;
  logic [ROOT_W-1:0] sq_root, dv_den;
  logic signed [DIV_W-1:0] dv_num, dv_quot;
  logic [15:0] co_angle;

  assign in_tready = (st_r == ST_IDLE);
  assign in_fire = in_tvalid & in_tready;
  assign out_free = !ov_r || out_tready;

  assign idx1 = (j_r == 2'd0) ? 2'd1 : ((j_r == 2'd1) ? 2'd2 : 2'd0);
  assign idx2 = (j_r == 2'd0) ? 2'd2 : ((j_r == 2'd1) ? 2'd0 : 2'd1);
  assign j1 = j_r + 2'd1;

  assign mac_last = ({1'b0, k_r} == phase_terms(ph_r) - 3'd1);
  assign outside = acc_r > ACC_W'(ONE_SQ);
  assign rs = (acc_r + ACC_W'(HALF)) >>> FRAC_BITS;
  assign mul_p = a_op * b_op;

  always_comb begin
    a_op = '0;
    b_op = '0;
    neg_op = 1'b0;
    unique case (ph_r)
      PH_SPH_S, PH_SPH_C: begin
        a_op = (k_r == 2'd0) ? val_t'(in_x_r) : val_t'(in_y_r);
        b_op = a_op;
      end
      PH_MAG_S: begin
        a_op = sp_r[k_r];
        b_op = a_op;
      end
      PH_MAG_C: begin
        a_op = cur_r[k_r];
        b_op = a_op;
      end
      PH_MAG_R: begin
        a_op = cr_r[k_r];
        b_op = a_op;
      end
      PH_CR: begin
        a_op = su_r[(k_r == 2'd0) ? idx1 : idx2];
        b_op = cu_r[(k_r == 2'd0) ? idx2 : idx1];
        neg_op = k_r[0];
      end
      PH_DOT: begin
        a_op = su_r[k_r];
        b_op = cu_r[k_r];
      end
      PH_QV: begin
        a_op = ax_r[j_r];
        b_op = val_t'({2'b00, sh_r});
      end
      PH_W: begin
        if (k_r == 2'd0) begin
          a_op = val_t'({2'b00, ch_r});
          b_op = val_t'(cq_r[0]);
        end else begin
          a_op = qv_r[k_r - 2'd1];
          b_op = val_t'(cq_r[k_r]);
          neg_op = 1'b1;
        end
      end
      PH_V: begin
        case (k_r)
          2'd0: begin
            a_op = val_t'({2'b00, ch_r});
            b_op = val_t'(cq_r[j1]);
          end
          2'd1: begin
            a_op = val_t'(cq_r[0]);
            b_op = qv_r[j_r];
          end
          2'd2: begin
            a_op = qv_r[idx1];
            b_op = val_t'(cq_r[idx2 + 2'd1]);
          end
          default: begin
            a_op = qv_r[idx2];
            b_op = val_t'(cq_r[idx1 + 2'd1]);
            neg_op = 1'b1;
          end
        endcase
      end
      PH_S: begin
        a_op = val_t'(pq_r[0]);
        b_op = a_op;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    post_fin = 1'b0;
    if (st_r == ST_POST) begin
      unique case (ph_r)
        PH_SPH_S, PH_SPH_C:                   post_fin = outside;
        PH_CR, PH_DOT, PH_QV, PH_W, PH_V:     post_fin = 1'b1;
        PH_AX:                                post_fin = (s_r == '0);
        default:                              post_fin = 1'b0;
      endcase
    end
  end

  assign sqrt_fin = (st_r == ST_SQRT) && sq_done &&
                    !((ph_r == PH_MAG_S || ph_r == PH_MAG_C || ph_r == PH_MAG_R) &&
                      (sq_root != '0));
  assign divw_fin = (st_r == ST_DIVW) && dv_done && (j_r == 2'd2);
  assign cord_fin = (st_r == ST_CORD) && co_done;
  assign fin = post_fin | sqrt_fin | divw_fin | cord_fin;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    ph_nxt = ph_r;
    j_nxt = j_r;
    k_nxt = k_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0]) begin
            if (in_tuser[1]) begin
              ph_nxt = PH_SPH_S;
              k_nxt = '0;
              j_nxt = '0;
              st_nxt = ST_MUL;
            end else begin
              st_nxt = ST_DONE;
            end
          end else if (drag_r) begin
            ph_nxt = PH_SPH_C;
            k_nxt = '0;
            j_nxt = '0;
            st_nxt = ST_MUL;
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: begin
        if (mac_last) begin
          st_nxt = ST_POST;
        end else begin
          k_nxt = k_r + 2'd1;
          st_nxt = ST_MUL;
        end
      end
      ST_POST: begin
        unique case (ph_r)
          PH_ANG:  st_nxt = ST_CORD;
          PH_AX: begin
            j_nxt = '0;
            st_nxt = ST_DIV;
          end
          default: st_nxt = ST_SQRT;
        endcase
      end
      ST_SQRT: begin
        if (sq_done) begin
          j_nxt = '0;
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: st_nxt = ST_DIVW;
      ST_DIVW: begin
        if (dv_done) begin
          j_nxt = j_r + 2'd1;
          st_nxt = ST_DIV;
        end
      end
      ST_CORD: begin
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (fin) begin
      if ((ph_r == PH_CR || ph_r == PH_QV || ph_r == PH_V) && j_r != 2'd2) begin
        j_nxt = j_r + 2'd1;
        k_nxt = '0;
        st_nxt = ST_MUL;
      end else if (ph_r == PH_SPH_S || ph_r == PH_AX) begin
        st_nxt = ST_DONE;
      end else begin
        ph_nxt = next_phase(ph_r);
        j_nxt = '0;
        k_nxt = '0;
        st_nxt = (phase_terms(next_phase(ph_r)) != 3'd0) ? ST_MUL : ST_POST;
      end
    end
  end

  // unit operands
  always_comb begin
    unique case (ph_r)
      PH_MAG_S, PH_SPH_S, PH_SPH_C, PH_S: sq_rad = RAD_W'(ACC_W'(ONE_SQ) - acc_r);
      PH_CH:   sq_rad = RAD_W'(ACC_W'(ONE) + ACC_W'(c_r)) << (FRAC_BITS - 1);
      PH_SH:   sq_rad = RAD_W'(ACC_W'(ONE) - ACC_W'(c_r)) << (FRAC_BITS - 1);
      default: sq_rad = RAD_W'(acc_r);
    endcase
    if (ph_r == PH_MAG_S) begin
      sq_rad = RAD_W'(acc_r);
    end
  end

  always_comb begin
    dv_den = mag_r;
    unique case (ph_r)
      PH_MAG_S: dv_num = DIV_W'(sp_r[j_r]) <<< FRAC_BITS;
      PH_MAG_C: dv_num = DIV_W'(cur_r[j_r]) <<< FRAC_BITS;
      PH_MAG_R: dv_num = DIV_W'(cr_r[j_r]) <<< FRAC_BITS;
      default: begin
        dv_num = DIV_W'(pq_r[j1]) <<< FRAC_BITS;
        dv_den = s_r;
      end
    endcase
  end

  // datapath
  always_comb begin
    in_x_nxt = in_x_r;
    in_y_nxt = in_y_r;
    sp_nxt = sp_r;
    cur_nxt = cur_r;
    su_nxt = su_r;
    cu_nxt = cu_r;
    cr_nxt = cr_r;
    ax_nxt = ax_r;
    qv_nxt = qv_r;
    mag_nxt = mag_r;
    ch_nxt = ch_r;
    sh_nxt = sh_r;
    s_nxt = s_r;
    c_nxt = c_r;
    cq_nxt = cq_r;
    pq_nxt = pq_r;
    ang_nxt = ang_r;
    axis_nxt = axis_r;
    drag_nxt = drag_r;
    prod_nxt = prod_r;
    acc_nxt = acc_r;
    od_nxt = od_r;
    ou_nxt = ou_r;
    ov_nxt = ov_r && !out_tready;
    sq_start = 1'b0;
    dv_start = 1'b0;
    co_start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          in_x_nxt = in_tdata[15:0];
          in_y_nxt = in_tdata[31:16];
          cur_nxt[0] = val_t'($signed(in_tdata[15:0]));
          cur_nxt[1] = val_t'($signed(in_tdata[31:16]));
          if (in_tuser[0]) begin
            if (in_tuser[1]) begin
              drag_nxt = 1'b1;
            end else if (in_tuser[2]) begin
              cq_nxt = pq_r;
              drag_nxt = 1'b0;
            end
          end
        end
      end
      ST_MUL: prod_nxt = neg_op ? -mul_p : mul_p;
      ST_ACC: acc_nxt = ((k_r == 2'd0) ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
      ST_POST: begin
        unique case (ph_r)
          PH_SPH_S: begin
            if (outside) begin
              sp_nxt[0] = val_t'(in_x_r);
              sp_nxt[1] = val_t'(in_y_r);
              sp_nxt[2] = '0;
            end else begin
              sq_start = 1'b1;
            end
          end
          PH_SPH_C: begin
            if (outside) begin
              cur_nxt[2] = '0;
            end else begin
              sq_start = 1'b1;
            end
          end
          PH_CR:  cr_nxt[j_r] = val_t'(rs);
          PH_DOT: c_nxt = clamp_one(rs);
          PH_QV:  qv_nxt[j_r] = val_t'(rs);
          PH_W:   pq_nxt[0] = clamp_one(rs);
          PH_V:   pq_nxt[j1] = clamp_one(rs);
          PH_ANG: co_start = 1'b1;
          PH_AX: begin
          end
          default: sq_start = 1'b1;
        endcase
      end
      ST_SQRT: begin
        if (sq_done) begin
          unique case (ph_r)
            PH_SPH_S: begin
              sp_nxt[0] = val_t'(in_x_r);
              sp_nxt[1] = val_t'(in_y_r);
              sp_nxt[2] = val_t'({2'b00, sq_root});
            end
            PH_SPH_C: cur_nxt[2] = val_t'({2'b00, sq_root});
            PH_MAG_S: begin
              mag_nxt = sq_root;
              if (sq_root == '0) begin
                su_nxt = '{default: '0};
              end
            end
            PH_MAG_C: begin
              mag_nxt = sq_root;
              if (sq_root == '0) begin
                cu_nxt = '{default: '0};
              end
            end
            PH_MAG_R: begin
              mag_nxt = sq_root;
              if (sq_root == '0) begin
                ax_nxt = '{default: '0};
              end
            end
            PH_CH:   ch_nxt = sq_root;
            PH_SH:   sh_nxt = sq_root;
            default: s_nxt = sq_root;
          endcase
        end
      end
      ST_DIV: dv_start = 1'b1;
      ST_DIVW: begin
        if (dv_done) begin
          unique case (ph_r)
            PH_MAG_S: su_nxt[j_r] = val_t'(dv_quot);
            PH_MAG_C: cu_nxt[j_r] = val_t'(dv_quot);
            PH_MAG_R: ax_nxt[j_r] = val_t'(dv_quot);
            default:  axis_nxt[j_r] = sat16(dv_quot);
          endcase
        end
      end
      ST_CORD: begin
        if (co_done) begin
          ang_nxt = co_angle;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          od_nxt = {axis_r[2], axis_r[1], axis_r[0], ang_r};
          ou_nxt = drag_r;
          ov_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    in_x_r <= in_x_nxt;
    in_y_r <= in_y_nxt;
    cur_r <= cur_nxt;
    su_r <= su_nxt;
    cu_r <= cu_nxt;
    cr_r <= cr_nxt;
    ax_r <= ax_nxt;
    qv_r <= qv_nxt;
    mag_r <= mag_nxt;
    ch_r <= ch_nxt;
    sh_r <= sh_nxt;
    s_r <= s_nxt;
    c_r <= c_nxt;
    prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    od_r <= od_nxt;
    ou_r <= ou_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    ph_r <= ph_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      drag_r <= 1'b0;
      sp_r <= '{default: '0};
      cq_r <= '{16'sh0000, qfx_t'(ONE), 16'sh0000, 16'sh0000};
      pq_r <= '{16'sh0000, qfx_t'(ONE), 16'sh0000, 16'sh0000};
      ang_r <= ANGLE_RESET;
      axis_r <= '{qfx_t'(ONE), 16'sh0000, 16'sh0000};
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      drag_r <= drag_nxt;
      sp_r <= sp_nxt;
      cq_r <= cq_nxt;
      pq_r <= pq_nxt;
      ang_r <= ang_nxt;
      axis_r <= axis_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

  arq_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  arq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  arq_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (co_start),
    .cx    (pq_r[0]),
    .sy    (s_r),
    .done  (co_done),
    .angle (co_angle)
  );

endmodule

// ===== rtl/arq_checker.sv =====
// Port-level assertions for the arcball rotation block and their binding.
module arq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while item in work");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] <= 16'd46080)
    else $error("angle out of range");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind arcball_quaternion_rotation arq_checker u_arq_checker (.*);

// ===== tb/arcball_quaternion_rotation_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the arcball rotation block with a built-in rotation predictor.
module arcball_quaternion_rotation_tb;
  import arq_pkg::*;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               drag;
  } rot_result_t;

  localparam longint QONE = 64'sd1 << FRAC_BITS;
  localparam longint QHALF = 64'sd1 << (FRAC_BITS - 1);
  localparam longint ATAN_TBL [20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;

  longint start_pt [3];
  longint commit_q [4];
  longint compose_q [4];
  longint angle_q7;
  longint axis_q [3];
  bit     drag_on;

  rot_result_t expected_rot [$];
  int          mismatches;
  int          burst_left;
  int          hold_cycles;
  int          sent_count;

  arcball_quaternion_rotation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint rnd(longint v);
    return (v + QHALF) >>> FRAC_BITS;
  endfunction

  function automatic longint clip_one(longint v);
    return (v > QONE) ? QONE : ((v < -QONE) ? -QONE : v);
  endfunction

  function automatic longint sat_16(longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic longint div_rnd(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint lift_z(longint x, longint y);
    longint r2;
    r2 = x * x + y * y;
    if (r2 > QONE * QONE) return 0;
    return longint'(isqrt(QONE * QONE - r2));
  endfunction

  function automatic void normalize(input longint v [3], output longint u [3]);
    longint mag;
    mag = longint'(isqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]));
    for (int i = 0; i < 3; i++) u[i] = (mag == 0) ? 0 : div_rnd(v[i] * QONE, mag);
  endfunction

  function automatic longint half_angle_deg(longint cx, longint sy);
    longint x, y, z, t, dx, dy;
    x = cx;
    y = sy;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd90 << 16;
    end
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd180 << 16)) z = 64'sd180 << 16;
    return z;
  endfunction

  task automatic rotate_to(longint x, longint y);
    longint cur [3], su [3], cu [3], cr [3], axn [3], qv [3], lv [3], v2 [3];
    longint c, ch, sh, lw, w2, s, dt;
    cur[0] = x; cur[1] = y; cur[2] = lift_z(x, y);
    normalize(start_pt, su);
    normalize(cur, cu);
    cr[0] = rnd(su[1] * cu[2] - su[2] * cu[1]);
    cr[1] = rnd(su[2] * cu[0] - su[0] * cu[2]);
    cr[2] = rnd(su[0] * cu[1] - su[1] * cu[0]);
    normalize(cr, axn);
    c = clip_one(rnd(su[0] * cu[0] + su[1] * cu[1] + su[2] * cu[2]));
    ch = longint'(isqrt((QONE + c) << (FRAC_BITS - 1)));
    sh = longint'(isqrt((QONE - c) << (FRAC_BITS - 1)));
    for (int i = 0; i < 3; i++) qv[i] = rnd(axn[i] * sh);
    lw = commit_q[0];
    for (int i = 0; i < 3; i++) lv[i] = commit_q[i + 1];
    dt = qv[0] * lv[0] + qv[1] * lv[1] + qv[2] * lv[2];
    w2 = clip_one(rnd(ch * lw - dt));
    v2[0] = clip_one(rnd(ch * lv[0] + lw * qv[0] + qv[1] * lv[2] - qv[2] * lv[1]));
    v2[1] = clip_one(rnd(ch * lv[1] + lw * qv[1] + qv[2] * lv[0] - qv[0] * lv[2]));
    v2[2] = clip_one(rnd(ch * lv[2] + lw * qv[2] + qv[0] * lv[1] - qv[1] * lv[0]));
    compose_q[0] = w2;
    for (int i = 0; i < 3; i++) compose_q[i + 1] = v2[i];
    s = longint'(isqrt(QONE * QONE - w2 * w2));
    angle_q7 = (2 * half_angle_deg(w2, s) + 256) >>> 9;
    if (s != 0) begin
      for (int i = 0; i < 3; i++) axis_q[i] = sat_16(div_rnd(v2[i] * QONE, s));
    end
  endtask

  task automatic reset_pose();
    for (int i = 0; i < 3; i++) start_pt[i] = 0;
    commit_q[0] = 0; commit_q[1] = QONE; commit_q[2] = 0; commit_q[3] = 0;
    compose_q = commit_q;
    angle_q7 = 64'sd180 << 7;
    axis_q[0] = sat_16(QONE); axis_q[1] = 0; axis_q[2] = 0;
    drag_on = 1'b0;
  endtask

  task automatic predict_rotation(bit act, logic signed [15:0] px, logic signed [15:0] py,
                                  bit chord, bit rel);
    rot_result_t r;
    if (act) begin
      if (chord) begin
        start_pt[0] = px;
        start_pt[1] = py;
        start_pt[2] = lift_z(px, py);
        drag_on = 1'b1;
      end else if (rel) begin
        commit_q = compose_q;
        drag_on = 1'b0;
      end
    end else if (drag_on) begin
      rotate_to(px, py);
    end
    r.angle = angle_q7[15:0];
    r.ax = axis_q[0][15:0];
    r.ay = axis_q[1][15:0];
    r.az = axis_q[2][15:0];
    r.drag = drag_on;
    expected_rot.push_back(r);
  endtask

  task automatic send_event(bit act, logic signed [15:0] px, logic signed [15:0] py,
                            bit chord, bit rel);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py, px};
    in_tuser <= {rel, chord, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_rotation(act, px, py, chord, rel);
    burst_left--;
    sent_count++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_rot.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord(bit wide);
    if (wide) return 16'($urandom);
    return 16'($signed($urandom_range(0, 40000)) - 20000);
  endfunction

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (($urandom_range(0, 2047) >> 9) & 3)
        0, 1:    out_tready <= 1'b1;
        2:       out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    rot_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", out_tdata);
      end else begin
        e = expected_rot.pop_front();
        if (out_tdata[15:0] !== e.angle || out_tdata[31:16] !== e.ax ||
            out_tdata[47:32] !== e.ay || out_tdata[63:48] !== e.az ||
            out_tuser !== e.drag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp angle %0d axis %0d %0d %0d drag %0d, got %0d %0d %0d %0d %0d",
                     e.angle, e.ax, e.ay, e.az, e.drag, out_tdata[15:0],
                     $signed(out_tdata[31:16]), $signed(out_tdata[47:32]),
                     $signed(out_tdata[63:48]), out_tuser);
        end
      end
    end
  end

  task automatic test_directed();
    send_event(0, 16'sd100, 16'sd200, 0, 0);
    send_event(1, 16'sd300, -16'sd300, 0, 0);
    send_event(1, 16'sd0, 16'sd0, 0, 1);
    send_event(1, 16'sd0, 16'sd0, 1, 0);
    send_event(0, 16'sd0, 16'sd0, 0, 0);
    send_event(0, 16'sd16384, 16'sd0, 0, 0);
    send_event(0, 16'sd32767, 16'sd32767, 0, 0);
    send_event(0, -16'sd32768, -16'sd32768, 0, 0);
    send_event(0, 16'sd0, -16'sd16384, 0, 0);
    send_event(1, 16'sd50, 16'sd50, 0, 0);
    send_event(1, 16'sd0, 16'sd0, 0, 1);
    send_event(1, -16'sd32768, 16'sd32767, 1, 1);
    send_event(0, 16'sd32767, -16'sd32768, 0, 0);
    send_event(0, 16'sd0, 16'sd16384, 0, 0);
    send_event(0, -16'sd16384, 16'sd0, 0, 0);
    send_event(1, 16'sd0, 16'sd0, 0, 1);
    send_event(0, 16'sd8000, 16'sd8000, 0, 0);
    send_event(1, 16'sd11585, 16'sd11585, 1, 0);
    send_event(0, -16'sd11585, -16'sd11585, 0, 0);
    send_event(1, 16'sd0, 16'sd0, 0, 1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    send_event(1, 16'sd4000, -16'sd2000, 1, 0);
    for (int i = 0; i < 6; i++) send_event(0, pick_coord(0), pick_coord(0), 0, 0);
    send_event(1, 16'sd0, 16'sd0, 0, 1);
    wait_drained();
  endtask

  task automatic test_random(int target);
    int moves;
    while (sent_count < target) begin
      if ($urandom_range(0, 9) < 8) begin
        send_event(1, pick_coord($urandom_range(0, 4) == 0),
                   pick_coord($urandom_range(0, 4) == 0), 1, $urandom_range(0, 1));
        moves = $urandom_range(1, 6);
        for (int i = 0; i < moves; i++)
          send_event(0, pick_coord($urandom_range(0, 5) == 0),
                     pick_coord($urandom_range(0, 5) == 0), $urandom_range(0, 1),
                     $urandom_range(0, 1));
        if ($urandom_range(0, 5) != 0)
          send_event(1, pick_coord(1), pick_coord(1), 0, 1);
      end else begin
        send_event($urandom_range(0, 1), pick_coord(1), pick_coord(1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    mismatches = 0;
    burst_left = 0;
    hold_cycles = 0;
    sent_count = 0;
    reset_pose();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1400);
    repeat (800) @(posedge clk);
    if (mismatches == 0 && expected_rot.size() == 0) begin
      $display("arcball_quaternion_rotation regression: pass");
    end else begin
      $display("arcball_quaternion_rotation regression: fail");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("arcball_quaternion_rotation regression: fail");
    $finish;
  end

endmodule
